// ===== rtl/bfa_pkg.sv =====
`timescale 1ns / 1ps
// Package for the best-fit block allocator: field widths, pool size, the table entry type
// and the types of the shared add/subtract unit. No dependencies.
package bfa_pkg;

   localparam int LEN_W               = 11;
   localparam int START_W             = 10;
   localparam int POOL_SIZE           = 1024;
   localparam int TABLE_SLOTS_DEFAULT = 64;

   typedef struct packed {
      logic               used;
      logic [LEN_W-1:0]   length;
      logic [START_W-1:0] start;
   } entry_type;

   typedef enum logic {
      ALU_SUB = 1'b0,
      ALU_ADD = 1'b1
   } alu_op_type;

   typedef struct packed {
      logic [LEN_W-1:0] value;
      logic             carry;
      logic             less;
   } alu_res_type;

endpackage

// ===== rtl/best_fit_block_allocator.sv =====
`timescale 1ns / 1ps
// Best-fit block allocator top level: sequencer, block table and shared add/subtract unit.
// Depends on bfa_pkg, bfa_table and bfa_alu.
//
// After reset the block sweeps the table once, one slot per cycle, with busy high. A
// request is taken when start is high and busy is low. A zero-size request never raises
// busy and is answered in the next cycle. Any other request scans every slot through the
// single memory read port and the shared subtractor, then refuses the item if no free
// block fits, or else marks the chosen block. When that block fits exactly or sits in the
// last slot, the result follows the mark; otherwise a split moves each later slot up by
// one, one slot per cycle, and then writes the leftover. The result appears on the rsp_
// ports for exactly one cycle with rsp_valid high and cannot be held off, so it must be
// captured in that cycle.
module best_fit_block_allocator #(
   parameter int TABLE_SLOTS = bfa_pkg::TABLE_SLOTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [bfa_pkg::LEN_W-1:0]     req_request_size,
   output logic                          busy,
   output logic                          rsp_valid,
   output logic                          rsp_granted,
   output logic [bfa_pkg::START_W-1:0]   rsp_start_address,
   output logic                          rsp_entry_dropped
);

   localparam int IW = $clog2(TABLE_SLOTS);
   localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SLOTS - 1);

   typedef enum logic [6:0] {
      ST_CLEAR  = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_SCAN   = 7'b0000100,
      ST_MARK   = 7'b0001000,
      ST_SHIFT  = 7'b0010000,
      ST_INSERT = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   state_type                      state_ff, state_in;
   logic [IW-1:0]                  idx_ff, idx_in;
   logic                           issue_done_ff, issue_done_in;
   logic                           pend_ff, pend_in;
   logic [IW-1:0]                  pend_idx_ff, pend_idx_in;
   logic [bfa_pkg::LEN_W-1:0]      req_ff, req_in;
   logic                           found_ff, found_in;
   logic [IW-1:0]                  best_idx_ff, best_idx_in;
   logic [bfa_pkg::LEN_W-1:0]      best_left_ff, best_left_in;
   logic [bfa_pkg::START_W-1:0]    best_start_ff, best_start_in;
   logic                           last_busy_ff, last_busy_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_granted_ff, rsp_granted_in;
   logic [bfa_pkg::START_W-1:0]    rsp_start_ff, rsp_start_in;
   logic                           rsp_dropped_ff, rsp_dropped_in;

   logic                           tbl_wr_en;
   logic [IW-1:0]                  tbl_wr_addr;
   bfa_pkg::entry_type             tbl_wr_data;
   logic                           tbl_rd_en;
   logic [IW-1:0]                  tbl_rd_addr;
   bfa_pkg::entry_type             tbl_rd_data;

   bfa_pkg::alu_op_type            alu_op;
   logic [bfa_pkg::LEN_W-1:0]      alu_a;
   bfa_pkg::alu_res_type           alu_res;
   logic                           fit;
   logic                           better;

   bfa_table #(
      .DEPTH (TABLE_SLOTS),
      .AW    (IW)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_en   (tbl_rd_en),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   bfa_alu u_alu (
      .op    (alu_op),
      .op_a  (alu_a),
      .op_b  (req_ff),
      .bound (best_left_ff),
      .res   (alu_res)
   );

   always_comb begin
      if (state_ff == ST_INSERT) begin
         alu_op = bfa_pkg::ALU_ADD;
         alu_a  = {1'b0, best_start_ff};
      end else begin
         alu_op = bfa_pkg::ALU_SUB;
         alu_a  = tbl_rd_data.length;
      end
      fit    = !tbl_rd_data.used && !alu_res.carry;
      better = fit && (!found_ff || alu_res.less);
   end

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      issue_done_in  = issue_done_ff;
      pend_in        = 1'b0;
      pend_idx_in    = pend_idx_ff;
      req_in         = req_ff;
      found_in       = found_ff;
      best_idx_in    = best_idx_ff;
      best_left_in   = best_left_ff;
      best_start_in  = best_start_ff;
      last_busy_in   = last_busy_ff;
      rsp_valid_in   = 1'b0;
      rsp_granted_in = rsp_granted_ff;
      rsp_start_in   = rsp_start_ff;
      rsp_dropped_in = rsp_dropped_ff;
      tbl_wr_en      = 1'b0;
      tbl_wr_addr    = idx_ff;
      tbl_wr_data    = '0;
      tbl_rd_en      = 1'b0;
      tbl_rd_addr    = idx_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            tbl_wr_en = 1'b1;
            if (idx_ff == '0) begin
               tbl_wr_data.length = bfa_pkg::LEN_W'(bfa_pkg::POOL_SIZE);
            end
            if (idx_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (start) begin
               req_in        = req_request_size;
               idx_in        = '0;
               issue_done_in = 1'b0;
               found_in      = 1'b0;
               best_left_in  = '0;
               if (req_request_size == '0) begin
                  rsp_valid_in   = 1'b1;
                  rsp_granted_in = 1'b0;
                  rsp_start_in   = '0;
                  rsp_dropped_in = 1'b0;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (!issue_done_ff) begin
               tbl_rd_en   = 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = idx_ff;
               if (idx_ff == LAST_IDX) begin
                  issue_done_in = 1'b1;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
            if (pend_ff) begin
               if (better) begin
                  found_in      = 1'b1;
                  best_idx_in   = pend_idx_ff;
                  best_left_in  = alu_res.value;
                  best_start_in = tbl_rd_data.start;
               end
               if (pend_idx_ff == LAST_IDX) begin
                  last_busy_in = (tbl_rd_data.length != '0);
                  if (better || found_ff) begin
                     state_in = ST_MARK;
                  end else begin
                     rsp_valid_in   = 1'b1;
                     rsp_granted_in = 1'b0;
                     rsp_start_in   = '0;
                     rsp_dropped_in = 1'b0;
                     state_in       = ST_IDLE;
                  end
               end
            end
         end
         ST_MARK: begin
            tbl_wr_en          = 1'b1;
            tbl_wr_addr        = best_idx_ff;
            tbl_wr_data.used   = 1'b1;
            tbl_wr_data.length = req_ff;
            tbl_wr_data.start  = best_start_ff;
            idx_in             = LAST_IDX - 1'b1;
            issue_done_in      = (LAST_IDX - 1'b1 == best_idx_ff);
            if (best_left_ff == '0 || best_idx_ff == LAST_IDX) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = 1'b1;
               rsp_start_in   = best_start_ff;
               rsp_dropped_in = (best_left_ff != '0);
               state_in       = ST_IDLE;
            end else begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            if (!issue_done_ff) begin
               tbl_rd_en   = 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = idx_ff + 1'b1;
               if (idx_ff == best_idx_ff + 1'b1) begin
                  issue_done_in = 1'b1;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end
            if (pend_ff) begin
               tbl_wr_en   = 1'b1;
               tbl_wr_addr = pend_idx_ff;
               tbl_wr_data = tbl_rd_data;
            end
            if (issue_done_ff && !pend_ff) begin
               state_in = ST_INSERT;
            end
         end
         ST_INSERT: begin
            tbl_wr_en          = 1'b1;
            tbl_wr_addr        = best_idx_ff + 1'b1;
            tbl_wr_data.used   = 1'b0;
            tbl_wr_data.length = best_left_ff;
            tbl_wr_data.start  = alu_res.value[bfa_pkg::START_W-1:0];
            state_in           = ST_DONE;
         end
         ST_DONE: begin
            rsp_valid_in   = 1'b1;
            rsp_granted_in = 1'b1;
            rsp_start_in   = best_start_ff;
            rsp_dropped_in = last_busy_ff;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         idx_ff        <= '0;
         issue_done_ff <= 1'b0;
         pend_ff       <= 1'b0;
         found_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         issue_done_ff <= issue_done_in;
         pend_ff       <= pend_in;
         found_ff      <= found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff    <= pend_idx_in;
      req_ff         <= req_in;
      best_idx_ff    <= best_idx_in;
      best_left_ff   <= best_left_in;
      best_start_ff  <= best_start_in;
      last_busy_ff   <= last_busy_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_start_ff   <= rsp_start_in;
      rsp_dropped_ff <= rsp_dropped_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_granted       = rsp_granted_ff;
   assign rsp_start_address = rsp_start_ff;
   assign rsp_entry_dropped = rsp_dropped_ff;

endmodule

// ===== rtl/bfa_alu.sv =====
`timescale 1ns / 1ps
// Shared add/subtract unit with a less-than compare of the result against a bound.
// Depends on bfa_pkg.
module bfa_alu (
   input  bfa_pkg::alu_op_type          op,
   input  logic [bfa_pkg::LEN_W-1:0]    op_a,
   input  logic [bfa_pkg::LEN_W-1:0]    op_b,
   input  logic [bfa_pkg::LEN_W-1:0]    bound,
   output bfa_pkg::alu_res_type         res
);

   logic [bfa_pkg::LEN_W:0] sum;

   always_comb begin
      if (op == bfa_pkg::ALU_ADD) begin
         sum = {1'b0, op_a} + {1'b0, op_b};
      end else begin
         sum = {1'b0, op_a} - {1'b0, op_b};
      end
      res.value = sum[bfa_pkg::LEN_W-1:0];
      res.carry = sum[bfa_pkg::LEN_W];
      res.less  = (sum[bfa_pkg::LEN_W-1:0] < bound);
   end

endmodule

// ===== rtl/bfa_table.sv =====
`timescale 1ns / 1ps
// Block table memory: one write port and one read port with registered read data.
// Depends on bfa_pkg.
module bfa_table #(
   parameter int DEPTH = bfa_pkg::TABLE_SLOTS_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  bfa_pkg::entry_type wr_data,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output bfa_pkg::entry_type rd_data
);

   bfa_pkg::entry_type mem [DEPTH];
   bfa_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bfa_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the best-fit block allocator, bound to the top level.
// Depends on best_fit_block_allocator and bfa_pkg.
module bfa_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic [bfa_pkg::LEN_W-1:0]     req_request_size,
   input logic                          busy,
   input logic                          rsp_valid,
   input logic                          rsp_granted,
   input logic [bfa_pkg::START_W-1:0]   rsp_start_address,
   input logic                          rsp_entry_dropped
);

   // The table sweep keeps the block busy right after reset.
   a_busy_after_reset: assert property (@(posedge clock)
      reset |=> busy)
      else $error("block not busy after reset");

   a_zero_refused: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_request_size == '0) |=> (rsp_valid && !rsp_granted))
      else $error("zero-size item not refused in the next cycle");

   a_busy_on_item: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_request_size != '0) |=> busy)
      else $error("block not busy after taking an item");

   a_refused_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_granted) |-> (rsp_start_address == '0 && !rsp_entry_dropped))
      else $error("refused result carries an address or a drop flag");

endmodule

bind best_fit_block_allocator bfa_checker u_bfa_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .req_request_size  (req_request_size),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_granted       (rsp_granted),
   .rsp_start_address (rsp_start_address),
   .rsp_entry_dropped (rsp_entry_dropped)
);
